/* rtl/assert_macros.svh */
// Assertion macros used by the checker of the tile plotter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PTPP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PTPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Delayed implication, checked at every rising clock edge outside reset.
`define PTPP_ASSERT_DLY3(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
    else $error("delayed implication failed");

`endif

/* rtl/ptpp_pkg.sv */
// Shared constants and control types of the tile plotter.
package ptpp_pkg;

  // Graphics ROM geometry: two interleaved byte banks, even and odd addresses.
  localparam int unsigned ROM_AW  = 17;
  localparam int unsigned BANK_AW = ROM_AW - 1;

  // Address offset of the right half of a tile row.
  localparam logic [ROM_AW-1:0] HALF_OFFSET = 17'd4096;

  // Palette base of the background layer.
  localparam logic [8:0] PEN_BASE = 9'd256;

  // Command codes of an input transaction.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rom_wr;      // write one ROM byte from the input transaction
    logic latch;       // capture the draw fields and clear the pixel counter
    logic rd_en;       // issue a read of both bytes of one row half
    logic rd_first;    // the read is for the first row half of the tile
    logic load_shift;  // move the fetched bytes into the pixel shifters
    logic advance;     // a pixel transaction completed
  } ptpp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic half_start;  // current pixel is the first of its row half
    logic last_half;   // current row half is the last of the tile
    logic half_end;    // current pixel is the last of its row half
    logic tile_end;    // current pixel is the last of the tile
  } ptpp_stat_t;

endpackage

/* rtl/ptpp_if.sv */
// Valid/ready channel interfaces for draw commands and plotted pixels.
interface ptpp_in_if (input logic clk);
  logic               valid;
  logic               ready;
  logic               command;
  logic [16:0]        load_address;
  logic [7:0]         load_data;
  logic [12:0]        tile_code;
  logic [3:0]         color;
  logic               flip_x;
  logic               flip_y;
  logic signed [9:0]  pos_x;
  logic signed [9:0]  pos_y;
  logic [3:0]         threshold;

  modport source (
    output valid, command, load_address, load_data, tile_code, color,
           flip_x, flip_y, pos_x, pos_y, threshold,
    input  ready
  );
  modport sink (
    input  valid, command, load_address, load_data, tile_code, color,
           flip_x, flip_y, pos_x, pos_y, threshold,
    output ready
  );
endinterface

interface ptpp_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [10:0] pixel_x;
  logic signed [10:0] pixel_y;
  logic [8:0]         pen;
  logic               write_enable;
  logic               last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pen, write_enable, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pen, write_enable, last_pixel,
    output ready
  );
endinterface

/* rtl/ptpp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptpp_ram #(
  parameter int unsigned AW = 16,
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* rtl/ptpp_datapath.sv */
// Datapath of the tile plotter: ROM banks, draw fields, pixel counter and shifters.
module ptpp_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ptpp_pkg::ptpp_cmd_t cmd,
  output ptpp_pkg::ptpp_stat_t stat,
  // Input transaction payload.
  input  logic [16:0]         load_address,
  input  logic [7:0]          load_data,
  input  logic [12:0]         tile_code,
  input  logic [3:0]          color,
  input  logic                flip_x,
  input  logic                flip_y,
  input  logic [9:0]          pos_x,
  input  logic [9:0]          pos_y,
  input  logic [3:0]          threshold,
  // Pixel payload.
  output logic [10:0]         pixel_x,
  output logic [10:0]         pixel_y,
  output logic [8:0]          pen,
  output logic                write_enable,
  output logic                last_pixel
);

  logic [12:0] code_r;
  logic [3:0]  color_r;
  logic        fx_r;
  logic        fy_r;
  logic [9:0]  px_r;
  logic [9:0]  py_r;
  logic [3:0]  thr_r;
  logic [5:0]  n_r;
  logic [5:0]  n_nxt;
  logic [7:0]  s0_r;
  logic [7:0]  s1_r;
  logic [7:0]  s0_nxt;
  logic [7:0]  s1_nxt;

  logic [3:0]                     rd_half;
  logic [ptpp_pkg::ROM_AW-1:0]    rd_base;
  logic [ptpp_pkg::ROM_AW-1:0]    half_add;
  logic                           wr_even;
  logic                           wr_odd;
  logic [7:0]                     even_q;
  logic [7:0]                     odd_q;
  logic [3:0]                     dot;
  logic [2:0]                     cx;
  logic [2:0]                     cy;

  // Draw fields are captured when the draw transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      code_r  <= tile_code;
      color_r <= color;
      fx_r    <= flip_x;
      fy_r    <= flip_y;
      px_r    <= pos_x;
      py_r    <= pos_y;
      thr_r   <= threshold;
    end
  end

  // Row-half index of the read: the first half, or the one after the current pixel's.
  always_comb begin
    rd_half  = cmd.rd_first ? 4'd0 : (n_r[5:2] + 4'd1);
    half_add = rd_half[0] ? ptpp_pkg::HALF_OFFSET : '0;
    rd_base  = {code_r, 4'b0000} + {13'd0, rd_half[3:1], 1'b0} + half_add;
  end

  // The row base is always even, so both bytes sit at one address of the two banks.
  assign wr_even = cmd.rom_wr && !load_address[0];
  assign wr_odd  = cmd.rom_wr &&  load_address[0];

  ptpp_ram #(.AW(ptpp_pkg::BANK_AW), .DW(8)) u_bank_even (
    .clk    (clk),
    .we     (wr_even),
    .waddr  (load_address[16:1]),
    .wdata  (load_data),
    .re     (cmd.rd_en),
    .raddr  (rd_base[16:1]),
    .rdata_r(even_q)
  );

  ptpp_ram #(.AW(ptpp_pkg::BANK_AW), .DW(8)) u_bank_odd (
    .clk    (clk),
    .we     (wr_odd),
    .waddr  (load_address[16:1]),
    .wdata  (load_data),
    .re     (cmd.rd_en),
    .raddr  (rd_base[16:1]),
    .rdata_r(odd_q)
  );

  // Pixel shifters: loaded at the start of each row half, shifted per pixel.
  always_comb begin
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (cmd.load_shift) begin
      s0_nxt = even_q;
      s1_nxt = odd_q;
    end else if (cmd.advance) begin
      s0_nxt = {s0_r[6:0], 1'b0};
      s1_nxt = {s1_r[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  // Pixel counter over the 64 pixels of the tile.
  always_comb begin
    n_nxt = n_r;
    if (cmd.latch) begin
      n_nxt = '0;
    end else if (cmd.advance) begin
      n_nxt = n_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else begin
      n_r <= n_nxt;
    end
  end

  // Pixel fields from the counter and the shifters.
  always_comb begin
    dot          = {s0_r[3], s0_r[7], s1_r[3], s1_r[7]};
    cx           = n_r[2:0] ^ {3{fx_r}};
    cy           = n_r[5:3] ^ {3{fy_r}};
    pixel_x      = {px_r[9], px_r} + {8'd0, cx};
    pixel_y      = {py_r[9], py_r} + {8'd0, cy};
    pen          = ptpp_pkg::PEN_BASE + {1'b0, color_r, dot};
    write_enable = (dot >= thr_r);
    last_pixel   = (n_r == 6'd63);
  end

  // Status to the controller.
  always_comb begin
    stat.half_start = (n_r[1:0] == 2'd0);
    stat.last_half  = (n_r[5:2] == 4'd15);
    stat.half_end   = (n_r[1:0] == 2'd3);
    stat.tile_end   = (n_r == 6'd63);
  end

endmodule

/* rtl/ptpp_ctrl.sv */
// Controller of the tile plotter: sequences loads, ROM fetches and pixel output.
module ptpp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ptpp_pkg::ptpp_stat_t stat,
  output ptpp_pkg::ptpp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_PRIME = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_command == ptpp_pkg::CMD_DRAW)) begin
          cmd.latch = 1'b1;
          state_nxt = ST_FETCH;
        end else if (in_valid) begin
          cmd.rom_wr = 1'b1;
        end
      end
      ST_FETCH: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = 1'b1;
        state_nxt    = ST_PRIME;
      end
      ST_PRIME: begin
        cmd.load_shift = 1'b1;
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        // Prefetch the next row half while the current one is shifted out.
        cmd.rd_en = stat.half_start && !stat.last_half;
        if (out_ready) begin
          cmd.advance = 1'b1;
          if (stat.tile_end) begin
            state_nxt = ST_IDLE;
          end else if (stat.half_end) begin
            cmd.load_shift = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/planar_tile_priority_plotter_unit.sv */
// Top level of the tile plotter: handshakes, controller and datapath.
// A load transaction writes one byte of the 128 KiB graphics ROM.
// A draw transaction is followed by the FETCH and PRIME states of ROM fetch, then the
// 64 pixels of the tile come out one per cycle while the sink is ready, rows top to
// bottom, left half then right half; no new transaction is taken until the tile's last
// pixel is accepted. The ROM is split into even and odd byte banks so both bytes of a
// row half arrive in one read, and the next half is fetched while the current one is
// shifted out. The ROM has no reset; only loaded bytes give defined pixels. Pixels
// below the threshold are still sent with write_enable low, and clipping is left to
// the consumer.
module planar_tile_priority_plotter_unit (
  input  logic      clk,
  input  logic      rst_n,
  ptpp_in_if.sink   in_ch,
  ptpp_out_if.source out_ch
);

  ptpp_pkg::ptpp_cmd_t  cmd;
  ptpp_pkg::ptpp_stat_t stat;
  logic [10:0]          pixel_x;
  logic [10:0]          pixel_y;

  // Sequencing of loads, fetches and pixel transactions.
  ptpp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_command(in_ch.command),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // ROM storage and pixel generation.
  ptpp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .load_address(in_ch.load_address),
    .load_data   (in_ch.load_data),
    .tile_code   (in_ch.tile_code),
    .color       (in_ch.color),
    .flip_x      (in_ch.flip_x),
    .flip_y      (in_ch.flip_y),
    .pos_x       (in_ch.pos_x),
    .pos_y       (in_ch.pos_y),
    .threshold   (in_ch.threshold),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pen         (out_ch.pen),
    .write_enable(out_ch.write_enable),
    .last_pixel  (out_ch.last_pixel)
  );

  assign out_ch.pixel_x = pixel_x;
  assign out_ch.pixel_y = pixel_y;

endmodule

/* rtl/ptpp_checker.sv */
// Port-level checker of the tile plotter and its bind to the top level.
`include "assert_macros.svh"

module ptpp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_command,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_pixel
);

  logic in_draw;
  logic in_load;
  logic out_last;

  assign in_draw  = in_valid && in_ready && (in_command == ptpp_pkg::CMD_DRAW);
  assign in_load  = in_valid && in_ready && (in_command == ptpp_pkg::CMD_LOAD);
  assign out_last = out_valid && out_ready && out_last_pixel;

  // No transaction is taken while pixels are pending.
  `PTPP_ASSERT_SAME(a_no_take_while_emit, clk, rst_n, out_valid, !in_ready)
  // A draw shows its first pixel after the fetch cycles.
  `PTPP_ASSERT_DLY3(a_draw_emits, clk, rst_n, in_draw, out_valid)
  // A load produces no pixel.
  `PTPP_ASSERT_NEXT(a_load_silent, clk, rst_n, in_load, !out_valid)
  // After the last pixel of a tile the block is ready again.
  `PTPP_ASSERT_NEXT(a_ready_after_tile, clk, rst_n, out_last, in_ready && !out_valid)

endmodule

bind planar_tile_priority_plotter_unit ptpp_checker u_ptpp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_command    (in_ch.command),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_last_pixel(out_ch.last_pixel)
);

/* tb/ptpp_tb_pkg.sv */
// Transaction types and the pixel scoreboard of the tile plotter testbench.
`timescale 1ns / 1ps
package ptpp_tb_pkg;
  import ptpp_pkg::*;

  localparam int unsigned ROM_BYTES = 1 << ROM_AW;
  localparam int unsigned REPORT_LIMIT = 10;

  // One input transaction: a ROM byte load or a tile draw.
  typedef struct {
    logic              command;
    logic [16:0]       load_address;
    logic [7:0]        load_data;
    logic [12:0]       tile_code;
    logic [3:0]        color;
    logic              flip_x;
    logic              flip_y;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic [3:0]        threshold;
  } plot_cmd_t;

  // One plotted pixel.
  typedef struct {
    logic signed [10:0] pixel_x;
    logic signed [10:0] pixel_y;
    logic [8:0]         pen;
    logic               write_enable;
    logic               last_pixel;
  } pixel_t;

  class pixel_scoreboard;
    logic [7:0] rom_image [ROM_BYTES];
    pixel_t     pending_pixels [$];
    int         mismatches;
    int         pixels_seen;
    int         loads_seen;
    int         draws_seen;

    function new();
      foreach (rom_image[i]) rom_image[i] = 8'h00;
      mismatches  = 0;
      pixels_seen = 0;
      loads_seen  = 0;
      draws_seen  = 0;
    endfunction

    // Applies a load to the ROM image, or expands a draw into its 64 pixels.
    function void note_command(plot_cmd_t cmd);
      logic [16:0] addr;
      logic [7:0]  d0;
      logic [7:0]  d1;
      logic [3:0]  dot;
      int          row;
      int          half;
      int          col;
      int          cx;
      int          cy;
      pixel_t      px;
      if (cmd.command == CMD_LOAD) begin
        rom_image[cmd.load_address] = cmd.load_data;
        loads_seen++;
        return;
      end
      draws_seen++;
      for (row = 0; row < 8; row++) begin
        for (half = 0; half < 2; half++) begin
          // Both bytes of a row half; the 17-bit sum wraps at the ROM end.
          addr = {cmd.tile_code, 4'd0} + 17'(row * 2) + ((half != 0) ? HALF_OFFSET : 17'd0);
          d0 = rom_image[addr];
          d1 = rom_image[17'(addr + 17'd1)];
          for (col = 0; col < 4; col++) begin
            dot = {d0[3], d0[7], d1[3], d1[7]};
            cx = col + half * 4;
            cy = row;
            if (cmd.flip_x) cx = 7 - cx;
            if (cmd.flip_y) cy = 7 - cy;
            px.pixel_x      = 11'(int'(cmd.pos_x) + cx);
            px.pixel_y      = 11'(int'(cmd.pos_y) + cy);
            px.pen          = PEN_BASE + {1'b0, cmd.color, dot};
            px.write_enable = (dot >= cmd.threshold);
            px.last_pixel   = (row == 7 && half == 1 && col == 3);
            pending_pixels.push_back(px);
            d0 = d0 << 1;
            d1 = d1 << 1;
          end
        end
      end
    endfunction

    // Compares one accepted pixel with the oldest expected pixel.
    function void check_pixel(pixel_t got);
      pixel_t want;
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("pixel %0d arrived with no draw pending: x=%0d y=%0d pen=%0d we=%0b last=%0b",
                   pixels_seen, got.pixel_x, got.pixel_y, got.pen, got.write_enable,
                   got.last_pixel);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.pen !== want.pen || got.write_enable !== want.write_enable ||
          got.last_pixel !== want.last_pixel) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("pixel %0d mismatch: expected x=%0d y=%0d pen=%0d we=%0b last=%0b, %s",
                   pixels_seen, want.pixel_x, want.pixel_y, want.pen, want.write_enable,
                   want.last_pixel,
                   $sformatf("got x=%0d y=%0d pen=%0d we=%0b last=%0b", got.pixel_x,
                             got.pixel_y, got.pen, got.write_enable, got.last_pixel));
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
// Top of the tile plotter testbench: clock, reset, drivers, monitors and the run sequence.
`timescale 1ns / 1ps
module tb_top;
  import ptpp_pkg::*;
  import ptpp_tb_pkg::*;

  localparam int RANDOM_ITEMS   = 110;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam logic [12:0] TOP_TILE = 13'h1FFF;

  logic clk;
  logic rst_n;

  ptpp_in_if  in_ch (clk);
  ptpp_out_if out_ch (clk);

  planar_tile_priority_plotter_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  pixel_scoreboard board = new();

  bit          rom_loaded [ROM_BYTES];
  int unsigned drawable_codes [$];
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          hold_request = 1'b0;
  bit          sender_quiet = 1'b0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Pause lengths: mostly short, now and then a long one.
  function automatic int pause_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Address of byte k of a tile: bytes 0..15 from the left half, 16..31 from the right.
  function automatic logic [16:0] tile_byte_addr(logic [12:0] code, int k);
    return {code, 4'd0} + 17'(k % 16) + ((k >= 16) ? HALF_OFFSET : 17'd0);
  endfunction

  function automatic logic [7:0] rom_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic plot_cmd_t load_command(logic [16:0] addr, logic [7:0] data);
    plot_cmd_t cmd;
    cmd.command      = CMD_LOAD;
    cmd.load_address = addr;
    cmd.load_data    = data;
    cmd.tile_code    = 13'($urandom);
    cmd.color        = 4'($urandom);
    cmd.flip_x       = 1'($urandom);
    cmd.flip_y       = 1'($urandom);
    cmd.pos_x        = 10'($urandom);
    cmd.pos_y        = 10'($urandom);
    cmd.threshold    = 4'($urandom);
    return cmd;
  endfunction

  function automatic plot_cmd_t draw_command(logic [12:0] code);
    plot_cmd_t cmd;
    int        r;
    cmd = load_command(17'($urandom), 8'($urandom));
    cmd.command   = CMD_DRAW;
    cmd.tile_code = code;
    r = $urandom_range(0, 9);
    if (r < 2) cmd.threshold = 4'd0;
    else if (r < 3) cmd.threshold = 4'd15;
    return cmd;
  endfunction

  // Offers one transaction and returns at the edge where it is accepted.
  task automatic send_command(plot_cmd_t cmd);
    int gap;
    gap = (sender_quiet || $urandom_range(0, 99) < 55) ? 0 : pause_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd.command;
    in_ch.load_address <= cmd.load_address;
    in_ch.load_data    <= cmd.load_data;
    in_ch.tile_code    <= cmd.tile_code;
    in_ch.color        <= cmd.color;
    in_ch.flip_x       <= cmd.flip_x;
    in_ch.flip_y       <= cmd.flip_y;
    in_ch.pos_x        <= cmd.pos_x;
    in_ch.pos_y        <= cmd.pos_y;
    in_ch.threshold    <= cmd.threshold;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Loads the bytes of a tile. A full load makes the tile drawable; a partial one
  // writes one to eight random bytes of the tile and does not make it drawable.
  task automatic load_tile(logic [12:0] code, bit full);
    logic [16:0] addr;
    int          k;
    int          n;
    if (full) begin
      for (k = 0; k < 32; k++) begin
        addr = tile_byte_addr(code, k);
        if (!rom_loaded[addr] || $urandom_range(0, 7) == 0) begin
          send_command(load_command(addr, rom_byte()));
          rom_loaded[addr] = 1'b1;
        end
      end
      drawable_codes.push_back(code);
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        addr = tile_byte_addr(code, $urandom_range(0, 31));
        send_command(load_command(addr, rom_byte()));
        rom_loaded[addr] = 1'b1;
      end
    end
  endtask

  // Stops offering and waits until every expected pixel has been accepted.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Monitors: inputs go to the predictor, pixels to the checker.
  always @(posedge clk) begin : monitors
    plot_cmd_t seen_cmd;
    pixel_t    seen_px;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_cmd.command      = in_ch.command;
      seen_cmd.load_address = in_ch.load_address;
      seen_cmd.load_data    = in_ch.load_data;
      seen_cmd.tile_code    = in_ch.tile_code;
      seen_cmd.color        = in_ch.color;
      seen_cmd.flip_x       = in_ch.flip_x;
      seen_cmd.flip_y       = in_ch.flip_y;
      seen_cmd.pos_x        = in_ch.pos_x;
      seen_cmd.pos_y        = in_ch.pos_y;
      seen_cmd.threshold    = in_ch.threshold;
      board.note_command(seen_cmd);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_px.pixel_x      = out_ch.pixel_x;
      seen_px.pixel_y      = out_ch.pixel_y;
      seen_px.pen          = out_ch.pen;
      seen_px.write_enable = out_ch.write_enable;
      seen_px.last_pixel   = out_ch.last_pixel;
      board.check_pixel(seen_px);
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pixel sink: stretches with and without stalls, plus one long hold on request.
  initial begin : pixel_sink
    int stall_left;
    int stretch_left;
    bit stalls_on;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    stretch_left = 0;
    stalls_on    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(30, 200);
        stalls_on    = ($urandom_range(0, 3) != 0);
      end
      stretch_left--;
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        stall_left = pause_length() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Run sequence.
  initial begin : run
    plot_cmd_t cmd;
    int        directed_items;
    int        choice;
    logic [12:0] code;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_LOAD;
    in_ch.load_address = '0;
    in_ch.load_data    = '0;
    in_ch.tile_code    = '0;
    in_ch.color        = '0;
    in_ch.flip_x       = 1'b0;
    in_ch.flip_y       = 1'b0;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.threshold    = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: loads at both ends of the address range, then the top tile,
    // whose right half wraps past the ROM end, drawn with extreme fields.
    send_command(load_command(17'h1FFFF, 8'hFF));
    rom_loaded[17'h1FFFF] = 1'b1;
    send_command(load_command(17'h00000, 8'h00));
    rom_loaded[17'h00000] = 1'b1;
    load_tile(TOP_TILE, 1'b1);

    cmd = draw_command(TOP_TILE);
    cmd.color = 4'd0;  cmd.threshold = 4'd0;  cmd.flip_x = 1'b0; cmd.flip_y = 1'b0;
    cmd.pos_x = -10'sd512; cmd.pos_y = -10'sd512;
    send_command(cmd);
    cmd = draw_command(TOP_TILE);
    cmd.color = 4'd15; cmd.threshold = 4'd15; cmd.flip_x = 1'b1; cmd.flip_y = 1'b0;
    cmd.pos_x = 10'sd511; cmd.pos_y = 10'sd511;
    send_command(cmd);
    cmd = draw_command(TOP_TILE);
    cmd.threshold = 4'd8; cmd.flip_x = 1'b0; cmd.flip_y = 1'b1;
    cmd.pos_x = 10'sd511; cmd.pos_y = -10'sd512;
    send_command(cmd);
    cmd = draw_command(TOP_TILE);
    cmd.threshold = 4'd1; cmd.flip_x = 1'b1; cmd.flip_y = 1'b1;
    cmd.pos_x = -10'sd512; cmd.pos_y = 10'sd511;
    send_command(cmd);
    wait_drain();

    // Back pressure: the sink holds off while draws keep coming back to back.
    hold_request = 1'b1;
    sender_quiet = 1'b1;
    repeat (3) send_command(draw_command(TOP_TILE));
    sender_quiet = 1'b0;
    directed_items = items_sent;

    // Random part: mostly draws of loaded tiles and well-formed load-then-draw
    // sequences, with partial loads and stray bytes as noise.
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) sender_quiet = ~sender_quiet;
      choice = $urandom_range(0, 99);
      if (choice < 72) begin
        code = 13'(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
        send_command(draw_command(code));
      end else if (choice < 86) begin
        // Chaining onto a loaded tile reuses one of its blocks.
        if ($urandom_range(0, 1) == 1)
          code = 13'(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)] + 256);
        else
          code = 13'($urandom_range(0, 8191));
        load_tile(code, 1'b1);
        send_command(draw_command(code));
      end else if (choice < 94) begin
        load_tile(13'($urandom_range(0, 8191)), 1'b0);
      end else if (choice < 97) begin
        cmd = load_command(17'($urandom), rom_byte());
        send_command(cmd);
        rom_loaded[cmd.load_address] = 1'b1;
      end else begin
        wait_drain();
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d loads and %0d draws accepted, %0d pixels checked, %0d mismatches",
             board.loads_seen, board.draws_seen, board.pixels_seen, board.mismatches);
    $display("summary: flips, threshold and position extremes, wrapped ROM reads, long stalls");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
